### rtl/core/mtfzr_pkg.sv
// Types and constants for the move-to-front zero-run decoder.
// Shared by the top level; no dependencies.
package mtfzr_pkg;

    localparam int unsigned TableDepth = 256;
    localparam int unsigned SymW       = 9;
    localparam int unsigned IncW       = 17;
    localparam int unsigned LenW       = 18;

    localparam logic [IncW-1:0] IncMax   = '1;
    localparam logic [SymW-1:0] SymLast  = 9'd256;
    localparam logic            AddrReg0 = 1'b0;

    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic            restart;
    } mtfzr_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] run_length;
        logic [15:0] byte_total;
        logic [15:0] space_left;
        logic        overrun;
    } mtfzr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHIFT,
        ST_FRONT,
        ST_COUNT,
        ST_FINISH
    } mtfzr_state_t;

endpackage

### rtl/core/mtf_zero_run_decoder.sv
// Move-to-front and zero-run back end of a block decompressor.
// Depends on mtfzr_pkg for payload types, the state enum and constants.
//
// Usage: one symbol beat enters on in_valid/in_stall and produces exactly one
// result beat on out_valid/out_stall. Symbols 0 and 1 are run digits that
// repeat the front table byte; symbols 2..256 emit a table entry and move it
// to the front. Setting restart starts a new block before the symbol is used.
// The table and the byte histogram live in two single-port-write memories
// with registered reads; valid bits give their reset contents.
// A run symbol passes through the fetch, count and finish states, and an
// error result goes straight to finish. A literal at table index k passes
// through fetch, shifts the k entries before it one place back, one per cycle
// through the table memory, then writes the byte at the front before finish.
// The next symbol can be accepted in the cycle after a result is loaded.
// One symbol is in work at a time; in_stall is high until its result has
// been loaded into the output register. A stalled result holds in that
// register while the next symbol is accepted and decoded.
// Reset empties the output register, loads the identity table and zero
// counts (through the valid bits), and sets the block length to out_length, limited to MAX_BLOCK.
// Configuration: APB, out_length at address 0; it takes effect at restart.
module mtf_zero_run_decoder #(
    parameter int unsigned MAX_BLOCK = 32768
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mtfzr_pkg::mtfzr_in_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mtfzr_pkg::mtfzr_out_t out_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mtfzr_pkg::*;

    // Configuration register.
    logic [15:0] out_length_reg;
    logic        cfg_wr;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == AddrReg0) && (paddr[1:0] == 2'b00);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {16'd0, out_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_length_reg <= 16'd32768;
        end
        else if (cfg_wr)
        begin
            out_length_reg <= pwdata[15:0];
        end
    end

    // Block length limited to the largest block.
    logic [15:0] blk_len;
    assign blk_len = (32'(out_length_reg) > 32'(MAX_BLOCK)) ? 16'(MAX_BLOCK)
                                                              : out_length_reg;

    // Control and working registers.
    mtfzr_state_t    state_reg, state_next;
    logic            err_reg, err_next;
    logic [IncW-1:0] inc_reg, inc_next;
    logic [15:0]     rem_reg, rem_next;
    logic            lit_reg, lit_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [7:0]      ptr_reg, ptr_next;
    logic [7:0]      byte_reg, byte_next;
    logic [15:0]     total_reg;
    logic            cnt_pend_reg, cnt_pend_next;
    logic            out_valid_reg, out_valid_next;
    mtfzr_out_t      out_reg;

    // Table memory ports.
    logic [7:0] mtf_mem [TableDepth];
    logic [TableDepth-1:0] mtf_vld_reg;
    logic       m_we;
    logic [7:0] m_waddr, m_wdata, m_raddr, m_q, m_raddr_q;
    logic       m_rv_reg;
    logic [7:0] m_val;

    // Count memory ports.
    logic [15:0] cnt_mem [TableDepth];
    logic [TableDepth-1:0] cnt_vld_reg;
    logic        c_we;
    logic [7:0]  c_raddr;
    logic [15:0] c_q, c_val, c_sum;
    logic        c_rv_reg;

    // Accepted beat and block state after an optional restart.
    logic            accept;
    logic [SymW-1:0] sym;
    logic            err0;
    logic [IncW-1:0] inc0;
    logic [15:0]     rem0;
    logic [LenW-1:0] run_len;
    logic [LenW:0]   inc_sum;
    logic            clear_vld;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign clear_vld = accept && in_beat.restart;
    assign sym       = (in_beat.symbol > SymLast) ? SymLast : in_beat.symbol;
    assign err0      = in_beat.restart ? 1'b0 : err_reg;
    assign inc0      = in_beat.restart ? IncW'(1) : inc_reg;
    assign rem0      = in_beat.restart ? blk_len : rem_reg;
    assign run_len   = LenW'(sym) + LenW'(inc0);
    assign inc_sum   = (LenW+1)'(inc0) + (LenW+1)'(run_len);

    assign m_val = m_rv_reg ? m_q : m_raddr_q;
    assign c_val = c_rv_reg ? c_q : 16'd0;
    assign c_sum = c_val + len_reg[15:0];

    // Next state, memory addresses and working values.
    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        inc_next       = inc_reg;
        rem_next       = rem_reg;
        lit_next       = lit_reg;
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        byte_next      = byte_reg;
        cnt_pend_next  = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        m_raddr        = 8'd0;
        m_we           = 1'b0;
        m_waddr        = ptr_reg;
        m_wdata        = m_val;
        c_raddr        = m_val;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    err_next   = err0;
                    inc_next   = inc0;
                    rem_next   = rem0;
                    lit_next   = (sym >= 9'd2);
                    len_next   = '0;
                    ptr_next   = 8'(sym - 9'd1);
                    m_raddr    = (sym >= 9'd2) ? 8'(sym - 9'd1) : 8'd0;
                    state_next = ST_FINISH;
                    if (!err0)
                    begin
                        state_next = ST_FETCH;
                        if (sym < 9'd2)
                        begin
                            inc_next = (inc_sum > (LenW+1)'(IncMax)) ? IncMax
                                                                     : IncW'(inc_sum);
                            if (run_len > LenW'(rem0))
                            begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                len_next = run_len;
                                rem_next = rem0 - run_len[15:0];
                            end
                        end
                        else
                        begin
                            inc_next = IncW'(1);
                            if (rem0 == 16'd0)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                len_next = LenW'(1);
                                rem_next = rem0 - 16'd1;
                            end
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                // Byte is known; start the count update and, for a literal, the shift.
                byte_next     = m_val;
                c_raddr       = m_val;
                cnt_pend_next = 1'b1;
                m_raddr       = 8'(ptr_reg - 8'd1);
                state_next    = lit_reg ? ST_SHIFT : ST_COUNT;
            end
            ST_SHIFT:
            begin
                // Entry ptr-1 arrives; store it one place further back.
                m_we     = 1'b1;
                m_waddr  = ptr_reg;
                m_wdata  = m_val;
                m_raddr  = 8'(ptr_reg - 8'd2);
                ptr_next = 8'(ptr_reg - 8'd1);
                if (ptr_reg == 8'd1)
                begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT:
            begin
                m_we       = 1'b1;
                m_waddr    = 8'd0;
                m_wdata    = byte_reg;
                state_next = ST_FINISH;
            end
            ST_COUNT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign c_we = cnt_pend_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_reg       <= 1'b0;
            inc_reg       <= IncW'(1);
            rem_reg       <= 16'(MAX_BLOCK > 32'd32768 ? 32'd32768 : MAX_BLOCK);
            cnt_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mtf_vld_reg   <= '0;
            cnt_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            inc_reg       <= inc_next;
            rem_reg       <= rem_next;
            cnt_pend_reg  <= cnt_pend_next;
            out_valid_reg <= out_valid_next;
            if (clear_vld)
            begin
                mtf_vld_reg <= '0;
                cnt_vld_reg <= '0;
            end
            else
            begin
                if (m_we)
                begin
                    mtf_vld_reg[m_waddr] <= 1'b1;
                end
                if (c_we)
                begin
                    cnt_vld_reg[byte_reg] <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lit_reg  <= lit_next;
        len_reg  <= len_next;
        ptr_reg  <= ptr_next;
        byte_reg <= byte_next;
        if (cnt_pend_reg)
        begin
            total_reg <= c_sum;
        end
        if ((state_reg == ST_FINISH) && (!out_valid_reg || !out_stall))
        begin
            if (err_reg)
            begin
                out_reg <= '{out_byte: 8'd0, run_length: 16'd0, byte_total: 16'd0,
                             space_left: rem_reg, overrun: 1'b1};
            end
            else
            begin
                out_reg <= '{out_byte: byte_reg, run_length: len_reg[15:0],
                             byte_total: total_reg, space_left: rem_reg,
                             overrun: 1'b0};
            end
        end
    end

    // Table memory: registered read, one write port.
    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mtf_mem[m_waddr] <= m_wdata;
        end
        m_q       <= mtf_mem[m_raddr];
        m_raddr_q <= m_raddr;
        m_rv_reg  <= clear_vld ? 1'b0 : mtf_vld_reg[m_raddr];
    end

    // Count memory: read in the fetch cycle, written back in the cycle after.
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cnt_mem[byte_reg] <= c_sum;
        end
        c_q      <= cnt_mem[c_raddr];
        c_rv_reg <= cnt_vld_reg[c_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // An error result carries no run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.overrun |-> out_beat.run_length == 16'd0)
        else $error("overrun result with nonzero run length");

    // A count write-back always follows the fetch cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> cnt_pend_reg)
        else $error("count update missing after fetch");

    // A result is only loaded from the finish state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish state");

    // The shift pointer never reaches the front entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> ptr_reg != 8'd0)
        else $error("shift pointer at front entry");
endmodule
